// ----- rtl/unsigned_to_ascii_radix_assert.svh -----
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_assert.svh
// Assertion macros for the radix converter RTL.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_RADIX_ASSERT_SVH
`define UNSIGNED_TO_ASCII_RADIX_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define UAR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define UAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/uar_pkg.sv -----
// ----------------------------------------------------------------------------
// uar_pkg
// Shared types, radix codes and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package uar_pkg;

  // Radix select codes
  localparam logic [1:0] CMD_DEC   = 2'd0;
  localparam logic [1:0] CMD_OCT   = 2'd1;
  localparam logic [1:0] CMD_HEX_L = 2'd2;
  localparam logic [1:0] CMD_HEX_U = 2'd3;

  // ASCII offsets
  localparam logic [7:0] ASCII_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] ASCII_HEX_U  = 8'h37;  // 'A' - 10
  localparam logic [7:0] ASCII_HEX_L  = 8'h57;  // 'a' - 10
  localparam logic [3:0] MAX_DEC_DIG  = 4'd9;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture a new value
    logic dabble;   // one double dabble step
    logic skip;     // drop a leading zero digit
    logic emit;     // move the top digit to the output register
  } uar_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic top_zero;   // most significant digit is zero
    logic cnt_one;    // one digit left
    logic bits_done;  // final double dabble step
  } uar_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic [1:0] cmd);
    logic [7:0] dx;
    dx = {4'd0, d};
    if (d <= MAX_DEC_DIG) begin
      digit_char = dx + ASCII_ZERO;
    end else if (cmd == CMD_HEX_U) begin
      digit_char = dx + ASCII_HEX_U;
    end else begin
      digit_char = dx + ASCII_HEX_L;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/uar_stream_if.sv -----
// ----------------------------------------------------------------------------
// uar_in_if / uar_out_if
// Valid/ready channels for the value input and the character output.
// ----------------------------------------------------------------------------
`default_nettype none

interface uar_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface uar_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/unsigned_to_ascii_radix.sv -----
// Sequence: load the value; for decimal, VALUE_WIDTH double dabble steps; skip leading
// zero digits; then one digit per cycle while the output is taken. A new value is
// accepted only in idle, after the final digit of the previous value has been emitted.
// Reset: synchronous active-low rst_n empties the output and returns to idle.
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix
// Converts an unsigned value into ASCII digits in decimal, octal or hex.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unsigned_to_ascii_radix_assert.svh"

module unsigned_to_ascii_radix
  import uar_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  uar_in_if.sink   in_ch,
  uar_out_if.source out_ch
);

  uar_cmd_t ctl;
  uar_sts_t sts;

  uar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  uar_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .in_cmd        (in_ch.cmd),
    .in_value      (in_ch.value),
    .ctl           (ctl),
    .sts           (sts),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

  // A fresh value never emits a digit in the cycle after it lands
  `UAR_ASSERT_NEXT(a_no_emit_after_load, in_ch.valid && in_ch.ready, !ctl.emit, "emit right after load")
  // No new value while digits are leaving
  `UAR_ASSERT_SAME(a_no_accept_in_emit, ctl.emit, !in_ch.ready, "accept during emit")
  // The final digit frees the input
  `UAR_ASSERT_NEXT(a_idle_after_last, ctl.emit && sts.cnt_one, in_ch.ready, "not idle after last digit")

endmodule

`default_nettype wire

// ----- rtl/uar_dpath.sv -----
// ----------------------------------------------------------------------------
// uar_dpath
// Digit register, double dabble step, digit counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uar_dpath
  import uar_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic [1:0]             in_cmd,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire uar_cmd_t               ctl,
  output      uar_sts_t               sts,
  output      logic [7:0]             out_character,
  output      logic                   out_last
);

  // Octal needs the most digits; decimal and hex fit in the same count
  localparam int NDIG = (VALUE_WIDTH + 2) / 3;
  localparam int DW   = 4 * NDIG;
  localparam int CW   = $clog2(NDIG + 1);
  localparam int BW   = $clog2(VALUE_WIDTH + 1);

  logic [DW-1:0]          digs_r, digs_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [BW-1:0]          bit_r, bit_nxt;
  logic [1:0]             cmd_r, cmd_nxt;
  logic [7:0]             char_r, char_nxt;
  logic                   last_r, last_nxt;

  logic [3*NDIG-1:0]      oct_src;
  logic [DW-1:0]          hex_src;
  logic [DW-1:0]          oct_digs;
  logic [DW-1:0]          adj;
  logic [3:0]             top;

  // Split the value into octal and hex digit fields
  assign oct_src = (3*NDIG)'(in_value);
  assign hex_src = DW'(in_value);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      oct_digs[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
    end
  end

  // Add three to every BCD digit of five or more
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (digs_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digs_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = digs_r[4*i +: 4];
      end
    end
  end

  assign top = digs_r[DW-1 -: 4];

  always_comb begin
    digs_nxt = digs_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    bit_nxt  = bit_r;
    cmd_nxt  = cmd_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (ctl.load) begin
      cmd_nxt = in_cmd;
      val_nxt = in_value;
      cnt_nxt = CW'(NDIG);
      bit_nxt = BW'(VALUE_WIDTH);
      unique case (in_cmd)
        CMD_DEC:              digs_nxt = '0;
        CMD_OCT:              digs_nxt = oct_digs;
        CMD_HEX_L, CMD_HEX_U: digs_nxt = hex_src;
        default:              digs_nxt = hex_src;
      endcase
    end else if (ctl.dabble) begin
      // Shift the next value bit into the corrected BCD digits
      digs_nxt = {adj[DW-2:0], val_r[VALUE_WIDTH-1]};
      val_nxt  = {val_r[VALUE_WIDTH-2:0], 1'b0};
      bit_nxt  = bit_r - BW'(1);
    end else if (ctl.skip || ctl.emit) begin
      // Advance to the next digit
      digs_nxt = {digs_r[DW-5:0], 4'd0};
      cnt_nxt  = cnt_r - CW'(1);
      if (ctl.emit) begin
        char_nxt = digit_char(top, cmd_r);
        last_nxt = sts.cnt_one;
      end
    end
  end

  always_ff @(posedge clk) begin
    digs_r <= digs_nxt;
    val_r  <= val_nxt;
    cnt_r  <= cnt_nxt;
    bit_r  <= bit_nxt;
    cmd_r  <= cmd_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign sts.top_zero  = (top == 4'd0);
  assign sts.cnt_one   = (cnt_r == CW'(1));
  assign sts.bits_done = (bit_r == BW'(1));

  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

// ----- rtl/uar_ctrl.sv -----
// ----------------------------------------------------------------------------
// uar_ctrl
// Sequencer: load, decimal conversion, leading zero skip and digit output.
// ----------------------------------------------------------------------------
`default_nettype none

module uar_ctrl
  import uar_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_cmd,
  output      logic       in_ready,
  output      logic       out_valid,
  input  wire logic       out_ready,
  input  wire uar_sts_t   sts,
  output      uar_cmd_t   ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = (in_cmd == CMD_DEC) ? S_CONV : S_SKIP;
        end
      end
      S_CONV: begin
        ctl.dabble = 1'b1;
        if (sts.bits_done) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts.top_zero && !sts.cnt_one) begin
          ctl.skip = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ctl.emit = 1'b1;
          if (sts.cnt_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the output beat until taken
  always_comb begin
    if (ctl.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire
